/* src/ivsu_pkg.sv */
// ivsu_pkg: item types, action and status codes for the interrupt vector
// and stack unit. No dependencies.

package ivsu_pkg;

  localparam logic [1:0] ACT_HW_INT  = 2'd0;
  localparam logic [1:0] ACT_SW_INT  = 2'd1;
  localparam logic [1:0] ACT_RETURN  = 2'd2;
  localparam logic [1:0] ACT_SET_VEC = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_IGNORED   = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_BADSET    = 3'd4;
  localparam logic [2:0] ST_BADSEG    = 3'd5;

  localparam int unsigned CFG_VECTORS_IN_USE  = 0;
  localparam int unsigned CFG_SEGMENTS_IN_USE = 1;

  localparam int unsigned VEC_ENTRY_W = 32;
  localparam int unsigned WORD_W      = 16;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] vector;
    logic [15:0] seg_in;
    logic [15:0] offset_in;
    logic [15:0] cur_ip;
    logic [15:0] cur_seg;
    logic [15:0] cur_flags;
  } in_item_t;

  typedef struct packed {
    logic [15:0] new_seg;
    logic [15:0] new_ip;
    logic [15:0] new_flags;
    logic [2:0]  status;
    logic        stack_fault;
    logic        raise_segfault;
    logic        interrupt_running;
  } out_item_t;

endpackage

/* src/ivsu_vtbl.sv */
// ivsu_vtbl: single-port vector table memory, segment in the upper half
// and offset in the lower half of each entry. Depends on ivsu_pkg.

module ivsu_vtbl #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      addr,
  input  logic [ivsu_pkg::VEC_ENTRY_W-1:0]   wdata,
  output logic [ivsu_pkg::VEC_ENTRY_W-1:0]   rdata
);

  logic [ivsu_pkg::VEC_ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/ivsu_stack.sv */
// ivsu_stack: single-port memory for the descending word stack.
// Depends on ivsu_pkg.

module ivsu_stack #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 addr,
  input  logic [ivsu_pkg::WORD_W-1:0]   wdata,
  output logic [ivsu_pkg::WORD_W-1:0]   rdata
);

  logic [ivsu_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/interrupt_vector_and_stack_unit_top.sv */
// Interrupt vector and stack unit: vector table, descending stack and the
// sequencer that runs the four actions. Depends on ivsu_pkg, ivsu_vtbl, ivsu_stack.
//
// After reset the unit sweeps the vector table to zero, one entry per cycle,
// and stalls the input meanwhile. Then it takes one item at a time. The
// vector table is read in the accept cycle and decided on in the next; a set
// vector, an ignored interrupt or any fault goes from EXEC straight to DONE,
// where its result is loaded. An interrupt that pushes and a good return move
// three stack words through the single stack port, one per cycle, in XFER.
// The result sits in an output register, so the next item can be accepted
// while it waits to be taken.

module interrupt_vector_and_stack_unit_top #(
  parameter int unsigned VECTORS     = 256,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ivsu_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ivsu_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [16:0]          cfg_wdata
);

  localparam int unsigned VAW = $clog2(VECTORS);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_XFER  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [VAW-1:0]      clr_cnt_r;
  ivsu_pkg::in_item_t  item_r;
  logic [SAW-1:0]      sp_r;
  logic                hact_r;
  logic [8:0]          viu_r;
  logic [16:0]         sgu_r;
  logic [1:0]          cnt_r;
  logic                rd_pend_r;
  logic [1:0]          rd_slot_r;
  logic                do_push_r, do_pop_r;
  logic [15:0]         res_seg_r, res_ip_r, res_flags_r, ret_ip_r;
  logic [2:0]          res_status_r;
  logic                res_fault_r, res_segv_r;
  logic                out_valid_r;
  ivsu_pkg::out_item_t out_data_r;

  logic                               vt_we;
  logic [VAW-1:0]                     vt_addr;
  logic [ivsu_pkg::VEC_ENTRY_W-1:0]   vt_wdata, vt_rdata;
  logic                               sk_we;
  logic [SAW-1:0]                     sk_addr;
  logic [ivsu_pkg::WORD_W-1:0]        sk_wdata, sk_rdata;

  // decision of the exec cycle
  logic        in_tbl, in_use, seg_ok, sp_low, sp_under, entry_empty;
  logic [15:0] ent_seg, ent_off;
  logic [15:0] ex_seg, ex_ip, ex_ret_ip;
  logic [2:0]  ex_status;
  logic        ex_fault, ex_segv, ex_push, ex_pop, ex_hact, ex_vt_we;

  logic accept, out_load;

  ivsu_vtbl #(.DEPTH(VECTORS), .AW(VAW)) u_vtbl (
    .clk   (clk),
    .we    (vt_we),
    .addr  (vt_addr),
    .wdata (vt_wdata),
    .rdata (vt_rdata)
  );

  ivsu_stack #(.DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .addr  (sk_addr),
    .wdata (sk_wdata),
    .rdata (sk_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign ent_seg     = vt_rdata[31:16];
  assign ent_off     = vt_rdata[15:0];
  assign entry_empty = (vt_rdata == '0);
  assign in_tbl      = ({1'b0, item_r.vector} < 17'(VECTORS));
  assign in_use      = in_tbl && (item_r.vector < {7'd0, viu_r});
  assign seg_ok      = ({1'b0, ent_seg} < sgu_r);
  assign sp_low      = (sp_r < SAW'(3));
  assign sp_under    = ({1'b0, sp_r} > (SAW + 1)'(STACK_DEPTH - 4));

  always_comb begin
    ex_seg    = item_r.cur_seg;
    ex_ip     = item_r.cur_ip;
    ex_ret_ip = item_r.cur_ip;
    ex_status = ivsu_pkg::ST_OK;
    ex_fault  = 1'b0;
    ex_segv   = 1'b0;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    ex_hact   = hact_r;
    ex_vt_we  = 1'b0;
    unique case (item_r.action)
      ivsu_pkg::ACT_HW_INT: begin
        if (!in_tbl || entry_empty) begin
          ex_status = ivsu_pkg::ST_IGNORED;
        end else begin
          // marked running even if the push then overflows
          ex_hact = 1'b1;
          if (sp_low) begin
            ex_status = ivsu_pkg::ST_OVERFLOW;
            ex_fault  = 1'b1;
          end else begin
            ex_push = 1'b1;
            if (!seg_ok) begin
              ex_status = ivsu_pkg::ST_BADSEG;
            end else begin
              ex_seg = ent_seg;
              ex_ip  = ent_off;
            end
          end
        end
      end
      ivsu_pkg::ACT_SW_INT: begin
        ex_ret_ip = item_r.cur_ip + 16'd2;
        if (!in_use) begin
          ex_status = ivsu_pkg::ST_IGNORED;
        end else if (sp_low) begin
          ex_status = ivsu_pkg::ST_OVERFLOW;
          ex_fault  = 1'b1;
        end else begin
          ex_push = 1'b1;
          if (!seg_ok) begin
            ex_status = ivsu_pkg::ST_BADSEG;
          end else begin
            ex_seg  = ent_seg;
            ex_ip   = ent_off;
            ex_hact = 1'b1;
          end
        end
      end
      ivsu_pkg::ACT_RETURN: begin
        if (sp_under) begin
          ex_status = ivsu_pkg::ST_UNDERFLOW;
          ex_fault  = 1'b1;
          ex_segv   = 1'b1;
        end else begin
          ex_pop  = 1'b1;
          ex_hact = 1'b0;
        end
      end
      ivsu_pkg::ACT_SET_VEC: begin
        if (!in_use) begin
          ex_status = ivsu_pkg::ST_BADSET;
          ex_segv   = 1'b1;
        end else begin
          ex_vt_we = 1'b1;
        end
      end
      default: begin
        ex_status = ivsu_pkg::ST_OK;
      end
    endcase
  end

  // vector table port: clear sweep, set-vector write, read at accept
  always_comb begin
    vt_we    = 1'b0;
    vt_addr  = in_data.vector[VAW-1:0];
    vt_wdata = {item_r.seg_in, item_r.offset_in};
    if (state_r == S_CLEAR) begin
      vt_we    = 1'b1;
      vt_addr  = clr_cnt_r;
      vt_wdata = '0;
    end else if (state_r == S_EXEC) begin
      vt_we   = ex_vt_we;
      vt_addr = item_r.vector[VAW-1:0];
    end
  end

  // stack port: push writes flags, return offset, segment going down;
  // pop reads segment, offset, flags going up
  always_comb begin
    sk_we    = (state_r == S_XFER) && do_push_r;
    sk_addr  = do_push_r ? (sp_r - SAW'(cnt_r)) : (sp_r + SAW'(cnt_r) + SAW'(1));
    unique case (cnt_r)
      2'd0:    sk_wdata = item_r.cur_flags;
      2'd1:    sk_wdata = ret_ip_r;
      default: sk_wdata = item_r.cur_seg;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == VAW'(VECTORS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = (ex_push || ex_pop) ? S_XFER : S_DONE;
      S_XFER:  if (cnt_r == 2'd2) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      sp_r        <= SAW'(STACK_DEPTH - 1);
      hact_r      <= 1'b0;
      viu_r       <= 9'd256;
      sgu_r       <= 17'd65536;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      do_push_r   <= 1'b0;
      do_pop_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + VAW'(1);
      end
      if (cfg_we) begin
        if (cfg_index == 1'(ivsu_pkg::CFG_VECTORS_IN_USE)) begin
          viu_r <= cfg_wdata[8:0];
        end else begin
          sgu_r <= cfg_wdata;
        end
      end
      if (state_r == S_EXEC) begin
        hact_r    <= ex_hact;
        do_push_r <= ex_push;
        do_pop_r  <= ex_pop;
      end
      if (state_r == S_XFER) begin
        cnt_r <= (cnt_r == 2'd2) ? 2'd0 : cnt_r + 2'd1;
      end
      rd_pend_r <= (state_r == S_XFER) && do_pop_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (do_push_r) begin
          sp_r <= sp_r - SAW'(3);
        end else if (do_pop_r) begin
          sp_r <= sp_r + SAW'(3);
        end
        do_push_r <= 1'b0;
        do_pop_r  <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    rd_slot_r <= cnt_r;
    if (state_r == S_EXEC) begin
      res_seg_r    <= ex_seg;
      res_ip_r     <= ex_ip;
      res_flags_r  <= item_r.cur_flags;
      ret_ip_r     <= ex_ret_ip;
      res_status_r <= ex_status;
      res_fault_r  <= ex_fault;
      res_segv_r   <= ex_segv;
    end else if (rd_pend_r) begin
      unique case (rd_slot_r)
        2'd0:    res_seg_r   <= sk_rdata;
        2'd1:    res_ip_r    <= sk_rdata;
        default: res_flags_r <= sk_rdata;
      endcase
    end
    if (out_load) begin
      out_data_r.new_seg   <= res_seg_r;
      out_data_r.new_ip    <= res_ip_r;
      // last popped word arrives in the first done cycle
      out_data_r.new_flags <= rd_pend_r ? sk_rdata : res_flags_r;
      out_data_r.status            <= res_status_r;
      out_data_r.stack_fault       <= res_fault_r;
      out_data_r.raise_segfault    <= res_segv_r;
      out_data_r.interrupt_running <= hact_r;
    end
  end

endmodule
